FILE: hw/rtl/rep_pkg.sv
// Shared types, widths and constants for the rotated ellipse point pipeline.
package rep_pkg;

  // Field widths of one input item.
  localparam int ANG_W = 32;
  localparam int AX_W  = 31;
  localparam int CEN_W = 32;

  // CORDIC datapath width: Q2.30 plus headroom for the intermediate growth.
  localparam int CS_W = 34;

  // Largest number of CORDIC iterations that the angle table supports.
  localparam int ATAN_N = 30;

  // Start value of x: the inverse CORDIC gain in Q2.30.
  localparam logic signed [CS_W-1:0] CORDIC_X0 = 34'sd652032874;

  // Side data that travels alongside the two CORDIC lanes.
  typedef struct packed {
    logic [AX_W-1:0]         axis_a;
    logic [AX_W-1:0]         axis_b;
    logic signed [CEN_W-1:0] center_x;
    logic signed [CEN_W-1:0] center_y;
  } side_t;

  // Arctangent of 2^-i as a binary angle, a full turn being 2^32.
  function automatic logic signed [CS_W-1:0] atan_val(input int idx);
    logic signed [CS_W-1:0] res;
    case (idx)
      0:       res = 34'sd536870912;
      1:       res = 34'sd316933406;
      2:       res = 34'sd167458907;
      3:       res = 34'sd85004756;
      4:       res = 34'sd42667331;
      5:       res = 34'sd21354465;
      6:       res = 34'sd10679838;
      7:       res = 34'sd5340245;
      8:       res = 34'sd2670163;
      9:       res = 34'sd1335087;
      10:      res = 34'sd667544;
      11:      res = 34'sd333772;
      12:      res = 34'sd166886;
      13:      res = 34'sd83443;
      14:      res = 34'sd41722;
      15:      res = 34'sd20861;
      16:      res = 34'sd10430;
      17:      res = 34'sd5215;
      18:      res = 34'sd2608;
      19:      res = 34'sd1304;
      20:      res = 34'sd652;
      21:      res = 34'sd326;
      22:      res = 34'sd163;
      23:      res = 34'sd81;
      24:      res = 34'sd41;
      25:      res = 34'sd20;
      26:      res = 34'sd10;
      27:      res = 34'sd5;
      28:      res = 34'sd3;
      29:      res = 34'sd1;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: hw/rtl/rep_if.sv
// Valid/ready channel interfaces for input and result items.
interface rep_in_if;
  import rep_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ANG_W-1:0]        orbit_angle;
  logic [ANG_W-1:0]        tilt_angle;
  logic [AX_W-1:0]         axis_a;
  logic [AX_W-1:0]         axis_b;
  logic signed [CEN_W-1:0] center_x;
  logic signed [CEN_W-1:0] center_y;

  modport source (output valid, orbit_angle, tilt_angle, axis_a, axis_b,
                  center_x, center_y, input ready);
  modport sink (input valid, orbit_angle, tilt_angle, axis_a, axis_b,
                center_x, center_y, output ready);
endinterface

interface rep_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic                          saturated;

  modport source (output valid, pos_x, pos_y, saturated, input ready);
  modport sink (input valid, pos_x, pos_y, saturated, output ready);
endinterface

FILE: hw/rtl/rep_cordic.sv
// One pipelined rotation-mode CORDIC lane with quadrant folding.
module rep_cordic #(
  parameter int STEPS = 16
) (
  input  logic                            clk,
  input  logic [STEPS:0]                  stage_en,
  input  logic [rep_pkg::ANG_W-1:0]       ang_i,
  output logic signed [rep_pkg::CS_W-1:0] cos_o,
  output logic signed [rep_pkg::CS_W-1:0] sin_o,
  output logic                            neg_o
);
  import rep_pkg::*;

  logic signed [CS_W-1:0] x_r   [0:STEPS];
  logic signed [CS_W-1:0] y_r   [0:STEPS];
  logic signed [CS_W-1:0] z_r   [0:STEPS];
  logic                   neg_r [0:STEPS];

  logic                   fold_neg;
  logic [ANG_W-1:0]       fold_ang;

  // Second and third quadrant angles get half a turn added; the result is negated later.
  always_comb begin
    fold_neg = (ang_i[ANG_W-1:ANG_W-2] == 2'b01) || (ang_i[ANG_W-1:ANG_W-2] == 2'b10);
    fold_ang = fold_neg ? (ang_i ^ {1'b1, {(ANG_W-1){1'b0}}}) : ang_i;
  end

  // Stage zero holds the start vector and the folded angle.
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      x_r[0]   <= CORDIC_X0;
      y_r[0]   <= '0;
      z_r[0]   <= CS_W'($signed(fold_ang));
      neg_r[0] <= fold_neg;
    end
  end

  // One micro-rotation per stage, steered by the sign of the residual angle.
  for (genvar k = 1; k <= STEPS; k++) begin : g_iter
    localparam logic signed [CS_W-1:0] ATAN = atan_val(k - 1);
    always_ff @(posedge clk) begin
      if (stage_en[k]) begin
        if (!z_r[k-1][CS_W-1]) begin
          x_r[k] <= x_r[k-1] - (y_r[k-1] >>> (k - 1));
          y_r[k] <= y_r[k-1] + (x_r[k-1] >>> (k - 1));
          z_r[k] <= z_r[k-1] - ATAN;
        end else begin
          x_r[k] <= x_r[k-1] + (y_r[k-1] >>> (k - 1));
          y_r[k] <= y_r[k-1] - (x_r[k-1] >>> (k - 1));
          z_r[k] <= z_r[k-1] + ATAN;
        end
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign cos_o = x_r[STEPS];
  assign sin_o = y_r[STEPS];
  assign neg_o = neg_r[STEPS];

endmodule

FILE: hw/rtl/rep_combine.sv
// Scaling, rotation, centering and saturation stages after the CORDIC lanes.
module rep_combine #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                             clk,
  input  logic [3:0]                       stage_en,
  input  logic signed [rep_pkg::CS_W-1:0]  ca_i,
  input  logic signed [rep_pkg::CS_W-1:0]  sa_i,
  input  logic                             na_i,
  input  logic signed [rep_pkg::CS_W-1:0]  cb_i,
  input  logic signed [rep_pkg::CS_W-1:0]  sb_i,
  input  logic                             nb_i,
  input  rep_pkg::side_t                   side_i,
  output logic signed [COORD_WIDTH-1:0]    pos_x_o,
  output logic signed [COORD_WIDTH-1:0]    pos_y_o,
  output logic                             sat_o
);
  import rep_pkg::*;

  localparam int PA_W = AX_W + 1 + CS_W;
  localparam int PR_W = 2 * CS_W;
  localparam int SM_W = PR_W + 1;
  localparam int EW   = (COORD_WIDTH > 36) ? COORD_WIDTH + 1 : 37;
  localparam logic signed [EW-1:0] HI = EW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] LO = -HI - EW'(1);

  // Stage A: undo the fold and scale by the semi-axes.
  logic signed [PA_W-1:0] pa_r, pb_r;
  logic signed [CS_W-1:0] cb_r, sb_r;
  side_t                  sa_side_r;
  logic signed [CS_W-1:0] ca_f, sa_f, cb_f, sb_f;

  always_comb begin
    ca_f = na_i ? -ca_i : ca_i;
    sa_f = na_i ? -sa_i : sa_i;
    cb_f = nb_i ? -cb_i : cb_i;
    sb_f = nb_i ? -sb_i : sb_i;
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      pa_r      <= $signed({1'b0, side_i.axis_a}) * ca_f;
      pb_r      <= $signed({1'b0, side_i.axis_b}) * sa_f;
      cb_r      <= cb_f;
      sb_r      <= sb_f;
      sa_side_r <= side_i;
    end
  end

  // Stage B: round to Q16.16 and form the four rotation products.
  logic signed [CS_W-1:0] u_rnd, v_rnd;
  logic signed [PR_W-1:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [CEN_W-1:0] cxb_r, cyb_r;

  always_comb begin
    u_rnd = CS_W'((pa_r + PA_W'(64'sd1 <<< 29)) >>> 30);
    v_rnd = CS_W'((pb_r + PA_W'(64'sd1 <<< 29)) >>> 30);
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      p1_r  <= u_rnd * cb_r;
      p2_r  <= v_rnd * sb_r;
      p3_r  <= u_rnd * sb_r;
      p4_r  <= v_rnd * cb_r;
      cxb_r <= sa_side_r.center_x;
      cyb_r <= sa_side_r.center_y;
    end
  end

  // Stage C: rotated sums with the rounding offset.
  logic signed [SM_W-1:0]  sx_r, sy_r;
  logic signed [CEN_W-1:0] cxc_r, cyc_r;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      sx_r  <= SM_W'(p1_r) - SM_W'(p2_r) + SM_W'(64'sd1 <<< 29);
      sy_r  <= SM_W'(p3_r) + SM_W'(p4_r) + SM_W'(64'sd1 <<< 29);
      cxc_r <= cxb_r;
      cyc_r <= cyb_r;
    end
  end

  // Stage D: add the center and clip to the coordinate range.
  logic signed [EW-1:0] x_sum, y_sum, x_clip, y_clip;
  logic                 x_sat, y_sat;

  always_comb begin
    x_sum  = EW'(sx_r >>> 30) + EW'(cxc_r);
    y_sum  = EW'(sy_r >>> 30) + EW'(cyc_r);
    x_sat  = (x_sum > HI) || (x_sum < LO);
    y_sat  = (y_sum > HI) || (y_sum < LO);
    x_clip = (x_sum > HI) ? HI : ((x_sum < LO) ? LO : x_sum);
    y_clip = (y_sum > HI) ? HI : ((y_sum < LO) ? LO : y_sum);
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      pos_x_o <= COORD_WIDTH'(x_clip);
      pos_y_o <= COORD_WIDTH'(y_clip);
      sat_o   <= x_sat || y_sat;
    end
  end

endmodule

FILE: hw/rtl/rotated_ellipse_point.sv
// Throughput: one item per cycle while out_ch.ready is high; each pipeline stage has its own valid bit
// and advances when it is empty or the stage after it moves, so bubbles close up.
// The depth is set by one input stage, one CORDIC iteration per stage and four scaling stages.
// Reset (synchronous, active low) clears all valid bits; payload registers keep their data.
module rotated_ellipse_point #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  rep_in_if.sink    in_ch,
  rep_out_if.source out_ch
);
  import rep_pkg::*;

  localparam int NS = CORDIC_STEPS + 5;

  logic [NS-1:0] valid_r;
  logic [NS-1:0] stage_en;

  // Each stage loads when it is empty or its content moves on.
  assign stage_en[NS-1] = !valid_r[NS-1] || out_ch.ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign stage_en[k] = !valid_r[k] || stage_en[k+1];
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (stage_en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign in_ch.ready  = stage_en[0];
  assign out_ch.valid = valid_r[NS-1];

  // Side data delayed to line up with the CORDIC outputs.
  side_t side_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      side_r[0] <= '{axis_a: in_ch.axis_a, axis_b: in_ch.axis_b,
                     center_x: in_ch.center_x, center_y: in_ch.center_y};
    end
    for (int k = 1; k <= CORDIC_STEPS; k++) begin
      if (stage_en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Two CORDIC lanes: the orbit angle and the negated tilt.
  logic signed [CS_W-1:0] ca, sa, cb, sb;
  logic                   na, nb;
  logic [ANG_W-1:0]       tilt_neg;

  assign tilt_neg = ANG_W'(0) - in_ch.tilt_angle;

  rep_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_orbit (
    .clk      (clk),
    .stage_en (stage_en[CORDIC_STEPS:0]),
    .ang_i    (in_ch.orbit_angle),
    .cos_o    (ca),
    .sin_o    (sa),
    .neg_o    (na)
  );

  rep_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_tilt (
    .clk      (clk),
    .stage_en (stage_en[CORDIC_STEPS:0]),
    .ang_i    (tilt_neg),
    .cos_o    (cb),
    .sin_o    (sb),
    .neg_o    (nb)
  );

  // Scaling, rotation, centering and clipping.
  rep_combine #(.COORD_WIDTH(COORD_WIDTH)) u_combine (
    .clk      (clk),
    .stage_en (stage_en[NS-1:CORDIC_STEPS+1]),
    .ca_i     (ca),
    .sa_i     (sa),
    .na_i     (na),
    .cb_i     (cb),
    .sb_i     (sb),
    .nb_i     (nb),
    .side_i   (side_r[CORDIC_STEPS]),
    .pos_x_o  (out_ch.pos_x),
    .pos_y_o  (out_ch.pos_y),
    .sat_o    (out_ch.saturated)
  );

endmodule
